// ===== rtl/core/hdc_pkg.sv =====
// shared types, register indexes and calendar tables for the holiday date classifier
package hdc_pkg;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } date_req_t;

    typedef struct packed {
        logic       is_major_holiday;
        logic       is_holiday;
        logic       is_pre_holiday;
        logic       is_saturday;
        logic       is_sunday;
        logic [2:0] easter_month;
        logic [4:0] easter_day;
    } class_result_t;

    localparam logic CFG_PATRON_MONTH = 1'b0;
    localparam logic CFG_PATRON_DAY   = 1'b1;

    localparam logic [3:0] PATRON_MONTH_RST = 4'd5;
    localparam logic [4:0] PATRON_DAY_RST   = 5'd30;

    // weekday offset of the first of each month
    function automatic logic [2:0] month_offset(input logic [3:0] mc);
        logic [2:0] r;
        begin
            case (mc)
                4'd1:    r = 3'd0;
                4'd2:    r = 3'd3;
                4'd3:    r = 3'd2;
                4'd4:    r = 3'd5;
                4'd5:    r = 3'd0;
                4'd6:    r = 3'd3;
                4'd7:    r = 3'd5;
                4'd8:    r = 3'd1;
                4'd9:    r = 3'd4;
                4'd10:   r = 3'd6;
                4'd11:   r = 3'd2;
                4'd12:   r = 3'd4;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    // century constant m of the computus, index 0 is the 1500s
    function automatic logic [4:0] cent_m(input logic [3:0] idx);
        logic [4:0] r;
        begin
            case (idx)
                4'd0, 4'd1:       r = 5'd22;
                4'd2, 4'd3:       r = 5'd23;
                4'd4, 4'd5, 4'd6: r = 5'd24;
                4'd7:             r = 5'd25;
                4'd8:             r = 5'd26;
                4'd9:             r = 5'd25;
                default:          r = 5'd25;
            endcase
            return r;
        end
    endfunction

    // century constant n of the computus
    function automatic logic [2:0] cent_n(input logic [3:0] idx);
        logic [2:0] r;
        begin
            case (idx)
                4'd0, 4'd1: r = 3'd2;
                4'd2:       r = 3'd3;
                4'd3:       r = 3'd4;
                4'd4, 4'd5: r = 3'd5;
                4'd6:       r = 3'd6;
                4'd7:       r = 3'd0;
                4'd8, 4'd9: r = 3'd1;
                default:    r = 3'd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mc, input logic leap);
        logic [4:0] r;
        begin
            case (mc)
                4'd2:                      r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
                default:                   r = 5'd31;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_fixed(input logic [3:0] m, input logic [4:0] d);
        logic r;
        begin
            case (m)
                4'd1:    r = d inside {5'd1, 5'd6};
                4'd4:    r = (d == 5'd25);
                4'd5:    r = (d == 5'd1);
                4'd6:    r = (d == 5'd2);
                4'd8:    r = (d == 5'd15);
                4'd11:   r = (d == 5'd1);
                4'd12:   r = d inside {5'd8, 5'd25, 5'd26};
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_major(
        input logic [3:0] m,
        input logic [4:0] d,
        input logic [2:0] em,
        input logic [4:0] ed,
        input logic [3:0] pm,
        input logic [4:0] pd
    );
        logic [3:0] mon_m;
        logic [4:0] mon_d;
        logic       r;
        begin
            // easter monday rolls into april when easter is march 31
            if (em == 3'd3 && ed == 5'd31)
            begin
                mon_m = 4'd4;
                mon_d = 5'd1;
            end
            else
            begin
                mon_m = {1'b0, em};
                mon_d = ed + 5'd1;
            end
            r = (m == {1'b0, em} && d == ed) || (m == mon_m && d == mon_d)
                || (m == pm && d == pd) || is_fixed(m, d);
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/holiday_date_classifier.sv =====
// holiday date classifier: six-stage pipeline from date request to calendar class
// a taken start runs down valid_reg beside the data in s1 to s5 and result_reg; done flags the result
// throughput: one request per cycle, busy stays low; the constant-reciprocal
// multipliers and the computus steps each take one stage
// reset: pipeline valid bits clear, patron day returns to may 30
// the receiver cannot stall, so each result is shown for exactly one cycle
module holiday_date_classifier
    import hdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  date_req_t     request,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [4:0]    cfg_data,
    output logic          done,
    output class_result_t result
);

    logic [3:0] patron_month_reg;
    logic [4:0] patron_day_reg;
    logic [6:1] valid_reg;

    // stage 1: quotients by reciprocal multiply
    logic [11:0] s1_y_reg;
    logic [3:0]  s1_m_reg;
    logic [4:0]  s1_d_reg;
    logic [7:0]  s1_q19_reg;
    logic [9:0]  s1_q7_reg;
    logic [5:0]  s1_c_reg;
    logic [25:0] prod19;
    logic [25:0] prod7;
    logic [25:0] prod100;

    // stage 2: residues, century constants, weekday sum, next day
    logic [3:0]  s2_m_reg;
    logic [4:0]  s2_d_reg;
    logic [4:0]  s2_a_reg;
    logic [1:0]  s2_b_reg;
    logic [2:0]  s2_cc_reg;
    logic [4:0]  s2_cm_reg;
    logic [2:0]  s2_cn_reg;
    logic [12:0] s2_w_reg;
    logic [3:0]  s2_nm_reg;
    logic [4:0]  s2_nd_reg;
    logic        s2_ny_reg;
    logic [4:0]  a_next;
    logic [2:0]  cc_next;
    logic [6:0]  r100;
    logic [11:0] a_full;
    logic [11:0] cc_full;
    logic [11:0] r100_full;
    logic [3:0]  mc;
    logic        adj;
    logic [3:0]  cidx;
    logic [12:0] yy;
    logic [5:0]  q100yy;
    logic [13:0] w_full;
    logic        leap;
    logic [3:0]  nm_next;
    logic [4:0]  nd_next;
    logic        ny_next;

    // stage 3: d of the computus and the weekday
    logic [3:0]  s3_m_reg;
    logic [4:0]  s3_d_reg;
    logic        s3_agt10_reg;
    logic [1:0]  s3_b_reg;
    logic [2:0]  s3_cc_reg;
    logic [2:0]  s3_cn_reg;
    logic [4:0]  s3_dd_reg;
    logic [2:0]  s3_wd_reg;
    logic [3:0]  s3_nm_reg;
    logic [4:0]  s3_nd_reg;
    logic        s3_ny_reg;
    logic [8:0]  x30;
    logic [17:0] prod30;
    logic [8:0]  dd_full;
    logic [26:0] prodw;
    logic [12:0] wd_full;

    // stage 4: e of the computus
    logic [3:0]  s4_m_reg;
    logic [4:0]  s4_d_reg;
    logic        s4_agt10_reg;
    logic [4:0]  s4_dd_reg;
    logic [2:0]  s4_e_reg;
    logic [2:0]  s4_wd_reg;
    logic [3:0]  s4_nm_reg;
    logic [4:0]  s4_nd_reg;
    logic        s4_ny_reg;
    logic [7:0]  x7;
    logic [16:0] prod7e;
    logic [7:0]  e_full;

    // stage 5: easter date
    logic [3:0]  s5_m_reg;
    logic [4:0]  s5_d_reg;
    logic [2:0]  s5_em_reg;
    logic [4:0]  s5_ed_reg;
    logic [2:0]  s5_wd_reg;
    logic [3:0]  s5_nm_reg;
    logic [4:0]  s5_nd_reg;
    logic        s5_ny_reg;
    logic [5:0]  de_sum;
    logic [4:0]  g;
    logic [2:0]  em_next;
    logic [4:0]  ed_next;

    // stage 6: classification
    class_result_t result_reg;
    class_result_t result_next;
    logic          major;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = valid_reg[6];
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patron_month_reg <= PATRON_MONTH_RST;
            patron_day_reg   <= PATRON_DAY_RST;
            valid_reg        <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:1], start};
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PATRON_MONTH: patron_month_reg <= cfg_data[3:0];
                    CFG_PATRON_DAY:   patron_day_reg   <= cfg_data;
                    default:          patron_day_reg   <= patron_day_reg;
                endcase
            end
        end
    end

    // stage 1
    always_comb
    begin
        prod19  = 26'(request.year) * 26'd13798;
        prod7   = 26'(request.year) * 26'd9363;
        prod100 = 26'(request.year) * 26'd10486;
    end

    always_ff @(posedge clk)
    begin
        s1_y_reg   <= request.year;
        s1_m_reg   <= request.month;
        s1_d_reg   <= request.day_of_month;
        s1_q19_reg <= prod19[25:18];
        s1_q7_reg  <= prod7[25:16];
        s1_c_reg   <= prod100[25:20];
    end

    // stage 2
    always_comb
    begin
        a_full    = s1_y_reg - 12'(s1_q19_reg) * 12'd19;
        cc_full   = s1_y_reg - 12'(s1_q7_reg) * 12'd7;
        r100_full = s1_y_reg - 12'(s1_c_reg) * 12'd100;
        a_next    = a_full[4:0];
        cc_next   = cc_full[2:0];
        r100      = r100_full[6:0];

        if (s1_m_reg == 4'd0)
            mc = 4'd1;
        else if (s1_m_reg > 4'd12)
            mc = 4'd12;
        else
            mc = s1_m_reg;

        if (s1_c_reg < 6'd15)
            cidx = 4'd0;
        else if (s1_c_reg > 6'd24)
            cidx = 4'd9;
        else
            cidx = 4'(s1_c_reg - 6'd15);

        // weekday counts january and february in the previous year
        adj    = (mc < 4'd3);
        yy     = 13'(s1_y_reg) + 13'd400 - 13'(adj);
        q100yy = s1_c_reg + 6'd4 - 6'(adj && r100 == 7'd0);
        w_full = 14'(yy) + 14'(yy[12:2]) + 14'(q100yy[5:2]) + 14'(month_offset(mc))
                 + 14'(s1_d_reg) - 14'(q100yy);

        leap = (s1_y_reg[1:0] == 2'd0 && r100 != 7'd0)
               || (r100 == 7'd0 && s1_c_reg[1:0] == 2'd0);

        nm_next = mc;
        nd_next = 5'd1;
        ny_next = 1'b0;
        if (s1_d_reg == 5'd0)
        begin
            nm_next = mc;
        end
        else if (s1_d_reg >= month_len(mc, leap))
        begin
            if (mc == 4'd12)
                ny_next = 1'b1;
            else
                nm_next = mc + 4'd1;
        end
        else
        begin
            nd_next = s1_d_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_m_reg  <= s1_m_reg;
        s2_d_reg  <= s1_d_reg;
        s2_a_reg  <= a_next;
        s2_b_reg  <= s1_y_reg[1:0];
        s2_cc_reg <= cc_next;
        s2_cm_reg <= cent_m(cidx);
        s2_cn_reg <= cent_n(cidx);
        s2_w_reg  <= w_full[12:0];
        s2_nm_reg <= nm_next;
        s2_nd_reg <= nd_next;
        s2_ny_reg <= ny_next;
    end

    // stage 3
    always_comb
    begin
        x30     = 9'(s2_a_reg) * 9'd19 + 9'(s2_cm_reg);
        prod30  = 18'(x30) * 18'd547;
        dd_full = x30 - 9'(prod30[17:14]) * 9'd30;
        prodw   = 27'(s2_w_reg) * 27'd9363;
        wd_full = s2_w_reg - 13'(prodw[26:16]) * 13'd7;
    end

    always_ff @(posedge clk)
    begin
        s3_m_reg     <= s2_m_reg;
        s3_d_reg     <= s2_d_reg;
        s3_agt10_reg <= (s2_a_reg > 5'd10);
        s3_b_reg     <= s2_b_reg;
        s3_cc_reg    <= s2_cc_reg;
        s3_cn_reg    <= s2_cn_reg;
        s3_dd_reg    <= dd_full[4:0];
        s3_wd_reg    <= wd_full[2:0];
        s3_nm_reg    <= s2_nm_reg;
        s3_nd_reg    <= s2_nd_reg;
        s3_ny_reg    <= s2_ny_reg;
    end

    // stage 4
    always_comb
    begin
        x7     = 8'(s3_b_reg) * 8'd2 + 8'(s3_cc_reg) * 8'd4 + 8'(s3_dd_reg) * 8'd6
                 + 8'(s3_cn_reg);
        prod7e = 17'(x7) * 17'd293;
        e_full = x7 - 8'(prod7e[16:11]) * 8'd7;
    end

    always_ff @(posedge clk)
    begin
        s4_m_reg     <= s3_m_reg;
        s4_d_reg     <= s3_d_reg;
        s4_agt10_reg <= s3_agt10_reg;
        s4_dd_reg    <= s3_dd_reg;
        s4_e_reg     <= e_full[2:0];
        s4_wd_reg    <= s3_wd_reg;
        s4_nm_reg    <= s3_nm_reg;
        s4_nd_reg    <= s3_nd_reg;
        s4_ny_reg    <= s3_ny_reg;
    end

    // stage 5
    always_comb
    begin
        de_sum = 6'(s4_dd_reg) + 6'(s4_e_reg);
        g      = 5'(de_sum - 6'd9);
        if (de_sum < 6'd10)
        begin
            em_next = 3'd3;
            ed_next = 5'(de_sum + 6'd22);
        end
        else
        begin
            em_next = 3'd4;
            // april 26 and the april 25 special case move back a week
            if (g == 5'd26 || (g == 5'd25 && s4_dd_reg == 5'd28 && s4_e_reg == 3'd6
                               && s4_agt10_reg))
                ed_next = g - 5'd7;
            else
                ed_next = g;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_m_reg  <= s4_m_reg;
        s5_d_reg  <= s4_d_reg;
        s5_em_reg <= em_next;
        s5_ed_reg <= ed_next;
        s5_wd_reg <= s4_wd_reg;
        s5_nm_reg <= s4_nm_reg;
        s5_nd_reg <= s4_nd_reg;
        s5_ny_reg <= s4_ny_reg;
    end

    // stage 6
    always_comb
    begin
        major = is_major(s5_m_reg, s5_d_reg, s5_em_reg, s5_ed_reg,
                         patron_month_reg, patron_day_reg);
        result_next.is_major_holiday = major;
        result_next.is_holiday       = major || (s5_wd_reg == 3'd0);
        result_next.is_pre_holiday   = s5_ny_reg
            || is_major(s5_nm_reg, s5_nd_reg, s5_em_reg, s5_ed_reg,
                        patron_month_reg, patron_day_reg);
        result_next.is_saturday      = (s5_wd_reg == 3'd6);
        result_next.is_sunday        = (s5_wd_reg == 3'd0);
        result_next.easter_month     = s5_em_reg;
        result_next.easter_day       = s5_ed_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== tb/tb_holiday_date_classifier.sv =====
// self-checking testbench for the holiday date classifier
module tb_holiday_date_classifier
    import hdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 112;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    date_req_t     request;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [4:0]    cfg_data;
    logic          done;
    class_result_t result;

    int stall_cycles = 0;

    holiday_date_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    class date_class_board;
        class_result_t pending_classes[$];
        logic [3:0]    patron_month;
        logic [4:0]    patron_day;
        int            errors;

        function new();
            patron_month = PATRON_MONTH_RST;
            patron_day   = PATRON_DAY_RST;
            errors       = 0;
        endfunction

        function void set_patron(logic idx, logic [4:0] data);
            if (idx == CFG_PATRON_MONTH)
                patron_month = data[3:0];
            else
                patron_day = data;
        endfunction

        function int month_days(int y, int m);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // gauss computus with the century table clamped to 1500s..2400s
        function void easter_of(int y, output int em, output int ed);
            int c, idx, cm, cn, a, b, cc, dd, e, g;
            c = y / 100;
            if (c < 15)
                c = 15;
            if (c > 24)
                c = 24;
            idx = c - 15;
            case (idx)
                0, 1:    cm = 22;
                2, 3:    cm = 23;
                4, 5, 6: cm = 24;
                7:       cm = 25;
                8:       cm = 26;
                default: cm = 25;
            endcase
            case (idx)
                0, 1:    cn = 2;
                2:       cn = 3;
                3:       cn = 4;
                4, 5:    cn = 5;
                6:       cn = 6;
                7:       cn = 0;
                default: cn = 1;
            endcase
            a  = y % 19;
            b  = y % 4;
            cc = y % 7;
            dd = (19 * a + cm) % 30;
            e  = (2 * b + 4 * cc + 6 * dd + cn) % 7;
            if (dd + e < 10)
            begin
                em = 3;
                ed = dd + e + 22;
            end
            else
            begin
                g = dd + e - 9;
                // the two april exception rules
                if (g == 26 || (g == 25 && dd == 28 && e == 6 && a > 10))
                    g -= 7;
                em = 4;
                ed = g;
            end
        endfunction

        function bit major_day(int m, int d, int em, int ed);
            int mon_m, mon_d;
            mon_m = em;
            mon_d = ed + 1;
            if (em == 3 && ed == 31)
            begin
                mon_m = 4;
                mon_d = 1;
            end
            if (m == em && d == ed)
                return 1'b1;
            if (m == mon_m && d == mon_d)
                return 1'b1;
            if (m == patron_month && d == patron_day)
                return 1'b1;
            case (m)
                1:       return d == 1 || d == 6;
                4:       return d == 25;
                5:       return d == 1;
                6:       return d == 2;
                8:       return d == 15;
                11:      return d == 1;
                12:      return d == 8 || d == 25 || d == 26;
                default: return 1'b0;
            endcase
        endfunction

        function class_result_t classify_date(date_req_t r);
            class_result_t c;
            int y, m, d, mc, em, ed, yy, ofs, wd;
            bit major, pre;
            y  = r.year;
            m  = r.month;
            d  = r.day_of_month;
            mc = (m < 1) ? 1 : ((m > 12) ? 12 : m);
            easter_of(y, em, ed);
            case (mc)
                2, 6:    ofs = 3;
                3, 11:   ofs = 2;
                4, 7:    ofs = 5;
                8:       ofs = 1;
                9, 12:   ofs = 4;
                10:      ofs = 6;
                default: ofs = 0;
            endcase
            yy = y + 400;
            if (mc < 3)
                yy -= 1;
            wd = (yy + yy / 4 - yy / 100 + yy / 400 + ofs + d) % 7;
            major = major_day(m, d, em, ed);
            if (d == 0)
                pre = major_day(mc, 1, em, ed);
            else if (d >= month_days(y, mc))
                pre = (mc == 12) ? 1'b1 : major_day(mc + 1, 1, em, ed);
            else
                pre = major_day(mc, d + 1, em, ed);
            c.is_major_holiday = major;
            c.is_holiday       = major || (wd == 0);
            c.is_pre_holiday   = pre;
            c.is_saturday      = (wd == 6);
            c.is_sunday        = (wd == 0);
            c.easter_month     = em[2:0];
            c.easter_day       = ed[4:0];
            return c;
        endfunction

        function void note_date(date_req_t r);
            pending_classes.push_back(classify_date(r));
        endfunction

        function void check_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_class(class_result_t got);
            class_result_t want;
            if (pending_classes.size() == 0)
            begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_classes.pop_front();
            check_field("is_major_holiday", want.is_major_holiday, got.is_major_holiday);
            check_field("is_holiday", want.is_holiday, got.is_holiday);
            check_field("is_pre_holiday", want.is_pre_holiday, got.is_pre_holiday);
            check_field("is_saturday", want.is_saturday, got.is_saturday);
            check_field("is_sunday", want.is_sunday, got.is_sunday);
            check_field("easter_month", want.easter_month, got.easter_month);
            check_field("easter_day", want.easter_day, got.easter_day);
        endfunction

        function int outstanding();
            return pending_classes.size();
        endfunction
    endclass

    date_class_board board = new();

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample handshakes and results at the rising edge
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                board.check_class(result);
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                board.note_date(request);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                board.set_patron(cfg_index, cfg_data);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_date(input int y, input int m, input int d);
        date_req_t r;
        r.year         = y[11:0];
        r.month        = m[3:0];
        r.day_of_month = d[4:0];
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_patron(input logic idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[4:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_classes();
        if (board.outstanding() > 0)
        begin
            start <= 1'b0;
            while (board.outstanding() > 0)
                @(negedge clk);
        end
    endtask

    // mostly valid dates, biased toward easter, fixed feasts, patron day and month ends
    task automatic pick_date(output int y, output int m, output int d);
        int kind, em, ed, bm, bd;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            y = $urandom_range(0, 4095);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
            return;
        end
        y = $urandom_range(1583, 2499);
        if (kind < 40)
        begin
            m = $urandom_range(1, 12);
            d = $urandom_range(1, board.month_days(y, m));
        end
        else if (kind < 60)
        begin
            board.easter_of(y, em, ed);
            m = em;
            d = ed - 1 + int'($urandom_range(0, 3));
            if (d > board.month_days(y, m))
            begin
                d -= board.month_days(y, m);
                m += 1;
            end
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 10))
                0:       begin bm = 1;  bd = 1;  end
                1:       begin bm = 1;  bd = 6;  end
                2:       begin bm = 4;  bd = 25; end
                3:       begin bm = 5;  bd = 1;  end
                4:       begin bm = 6;  bd = 2;  end
                5:       begin bm = 8;  bd = 15; end
                6:       begin bm = 11; bd = 1;  end
                7:       begin bm = 12; bd = 8;  end
                8:       begin bm = 12; bd = 25; end
                9:       begin bm = 12; bd = 26; end
                default: begin bm = board.patron_month; bd = board.patron_day; end
            endcase
            m = bm;
            d = bd - 1 + int'($urandom_range(0, 2));
            if (d == 0)
            begin
                m = 12;
                d = 31;
            end
            else if (d > board.month_days(y, m))
            begin
                m = m % 12 + 1;
                d = 1;
            end
        end
        else
        begin
            m = $urandom_range(1, 12);
            d = board.month_days(y, m) - int'($urandom_range(0, 1));
        end
    endtask

    task automatic run_random(input int count, input int idle_pct);
        int y, m, d, burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 99) < 5)
                burst_left = $urandom_range(8, 30);
            else
            begin
                while ($urandom_range(0, 99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(negedge clk);
                end
            end
            // now and then let the pipeline run dry
            if ($urandom_range(0, 99) == 0)
                drain_classes();
            pick_date(y, m, d);
            send_date(y, m, d);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PATRON_MONTH;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed dates under the reset patron day
        send_date(1583, 1, 1);
        send_date(2499, 12, 31);
        send_date(0, 0, 0);
        send_date(4095, 15, 31);
        send_date(1818, 3, 22);
        send_date(1818, 3, 21);
        send_date(1943, 4, 25);
        send_date(1943, 4, 26);
        send_date(2024, 3, 31);
        send_date(2024, 4, 1);
        send_date(1981, 4, 19);
        send_date(1954, 4, 18);
        send_date(2024, 5, 30);
        send_date(2024, 5, 29);
        send_date(2023, 12, 24);
        send_date(2023, 12, 26);
        send_date(2000, 2, 29);
        send_date(1900, 2, 28);
        send_date(2023, 2, 30);
        send_date(2023, 0, 5);
        send_date(2023, 13, 31);
        send_date(2023, 6, 1);
        send_date(2023, 8, 15);
        send_date(2024, 1, 0);
        send_date(2024, 6, 2);

        run_random(ITEMS_PER_PHASE, 0);

        drain_classes();
        write_patron(CFG_PATRON_MONTH, 12);
        write_patron(CFG_PATRON_DAY, 31);
        send_date(2023, 12, 30);
        send_date(2023, 12, 31);
        run_random(ITEMS_PER_PHASE, 61);

        drain_classes();
        write_patron(CFG_PATRON_DAY, 1);
        write_patron(CFG_PATRON_MONTH, 1);
        run_random(ITEMS_PER_PHASE, 0);

        drain_classes();
        write_patron(CFG_PATRON_MONTH, $urandom_range(1, 12));
        write_patron(CFG_PATRON_DAY, $urandom_range(1, 31));
        run_random(ITEMS_PER_PHASE, 25);

        drain_classes();
        repeat (8) @(negedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/hdc_pkg.sv
rtl/core/holiday_date_classifier.sv
tb/tb_holiday_date_classifier.sv
